FILE: rtl/core/selective_ack_window_receiver_top_assert.svh
// assertion macros for the selective ack window receiver
`ifndef SELECTIVE_ACK_WINDOW_RECEIVER_TOP_ASSERT_SVH
`define SELECTIVE_ACK_WINDOW_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SAWR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sawr assertion failed");

// next-cycle implication, disabled in reset
`define SAWR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sawr assertion failed");

`endif

FILE: rtl/core/sawr_pkg.sv
// ----------------------------------------------------------------------------
// sawr_pkg
// types and constants shared by the selective ack window receiver
// ----------------------------------------------------------------------------
package sawr_pkg;

  localparam logic [7:0]  SEQ_START   = 8'hFF;
  localparam logic [7:0]  SEQ_END     = 8'hFE;
  localparam logic [7:0]  SEQ_CSUM    = 8'hFD;
  localparam logic [7:0]  BASE_RESET  = 8'hEF;
  localparam logic [7:0]  BASE_LIMIT  = 8'hF0;
  localparam logic [13:0] BUF_MAX     = 14'h3FFF;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 3;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [2:0] {
    KIND_IGNORE,
    KIND_TIMEOUT,
    KIND_START,
    KIND_END,
    KIND_CSUM,
    KIND_DATA
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  seq;
    logic [7:0]  seq_quot;
    logic [10:0] payload_len;
    logic [31:0] announced_size;
  } entry_t;

  typedef struct packed {
    logic        accepted;
    logic        send_ack;
    logic [7:0]  ack_seq;
    logic [7:0]  ack_bits;
    logic        store_chunk;
    logic [2:0]  store_slot;
    logic        flush;
    logic [13:0] flush_bytes;
    logic        checksum_request;
    logic        protocol_error;
  } result_t;

endpackage

FILE: rtl/core/sawr_front.sv
// ----------------------------------------------------------------------------
// sawr_front
// holds the station address, filters and classifies incoming headers
// ----------------------------------------------------------------------------
module sawr_front #(
  parameter int WINDOW = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  input  logic [47:0]                        cfg_data,
  input  logic                               func,
  input  logic [47:0]                        dest_mac,
  input  logic [15:0]                        ether_type,
  input  logic [7:0]                         seq,
  input  logic [10:0]                        payload_len,
  input  logic [31:0]                        announced_size,
  output sawr_pkg::entry_t                   entry
);
  import sawr_pkg::*;

  // reciprocal for seq / WINDOW, exact for all 8-bit seq values
  localparam logic [16:0] RECIP = 17'((65536 + WINDOW - 1) / WINDOW);

  logic [47:0] own_mac;
  logic [24:0] quot_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
    end else if (cfg_valid) begin
      own_mac <= cfg_data;
    end
  end

  assign quot_prod = 25'(seq) * 25'(RECIP);

  always_comb begin
    entry.seq            = seq;
    entry.seq_quot       = quot_prod[23:16];
    entry.payload_len    = payload_len;
    entry.announced_size = announced_size;
    if (func) begin
      entry.kind = KIND_TIMEOUT;
    end else if (ether_type != 16'd0 || dest_mac != own_mac) begin
      entry.kind = KIND_IGNORE;
    end else if (seq == SEQ_START) begin
      entry.kind = KIND_START;
    end else if (seq == SEQ_END) begin
      entry.kind = KIND_END;
    end else if (seq == SEQ_CSUM) begin
      entry.kind = KIND_CSUM;
    end else begin
      entry.kind = KIND_DATA;
    end
  end

endmodule

FILE: rtl/core/sawr_fifo.sv
// ----------------------------------------------------------------------------
// sawr_fifo
// short queue of classified headers between front and back
// ----------------------------------------------------------------------------
module sawr_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sawr_pkg::entry_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sawr_pkg::entry_t  head_data
);
  import sawr_pkg::*;

  entry_t                slots [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full       = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + FIFO_CNT_W'(1);
        2'b01:   count <= count - FIFO_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/sawr_back.sv
// ----------------------------------------------------------------------------
// sawr_back
// window state update and registered result
// ----------------------------------------------------------------------------
module sawr_back #(
  parameter int WINDOW      = 8,
  parameter int CHUNK_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sawr_pkg::entry_t  in_entry,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sawr_pkg::result_t out_result
);
  import sawr_pkg::*;

  localparam int          SLOT_W    = $clog2(WINDOW);
  localparam logic [31:0] WIN_BYTES = 32'(WINDOW * CHUNK_BYTES);
  localparam logic [7:0]  BASE_WRAP = 8'(240 - WINDOW);
  localparam logic [WINDOW-1:0] FULL_MASK = {WINDOW{1'b1}};

  logic [7:0]        window_base,    window_base_next;
  logic [WINDOW-1:0] slot_bitmap,    slot_bitmap_next;
  logic              window_full,    window_full_next;
  logic [13:0]       bytes_buffered, bytes_buffered_next;
  logic [31:0]       total_written,  total_written_next;
  logic [31:0]       expected_size,  expected_size_next;
  logic              first_packet,   first_packet_next;
  result_t           res;

  logic                 take;
  logic [15:0]          quot_mul;
  logic [15:0]          rem;
  logic [SLOT_W-1:0]    slot;
  logic [WINDOW-1:0]    slot_bit;
  logic signed [9:0]    seq_dist;
  logic                 beyond;
  logic [8:0]           base_sum;
  logic [14:0]          buf_sum;
  logic [31:0]          slot_span;
  logic [32:0]          reach;
  logic [WINDOW+7:0]    bm_ext;
  logic [SLOT_W+2:0]    slot_ext;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  assign quot_mul = 16'(in_entry.seq_quot) * 16'(WINDOW);
  assign rem      = 16'(in_entry.seq) - quot_mul;
  assign slot     = rem[SLOT_W-1:0];
  assign slot_bit = WINDOW'(1) << slot;
  assign slot_ext = {3'd0, slot};

  always_comb begin
    seq_dist = $signed({2'b00, in_entry.seq}) - $signed({2'b00, window_base});
    if (seq_dist < 0) begin
      seq_dist = $signed(10'd239) - $signed({2'b00, window_base})
                 + $signed({2'b00, in_entry.seq});
    end
  end

  assign beyond = (seq_dist >= $signed(10'(WINDOW)));

  always_comb begin
    window_base_next    = window_base;
    slot_bitmap_next    = slot_bitmap;
    window_full_next    = window_full;
    bytes_buffered_next = bytes_buffered;
    total_written_next  = total_written;
    expected_size_next  = expected_size;
    first_packet_next   = first_packet;
    res                 = '0;
    base_sum            = '0;
    buf_sum             = '0;
    slot_span           = '0;
    reach               = '0;
    bm_ext              = '0;
    case (in_entry.kind)
      KIND_TIMEOUT: begin
        if (!first_packet) begin
          bm_ext       = {8'd0, slot_bitmap};
          res.send_ack = 1'b1;
          res.ack_seq  = window_base;
          res.ack_bits = bm_ext[7:0];
        end
      end
      KIND_START: begin
        res.accepted        = 1'b1;
        res.send_ack        = 1'b1;
        res.ack_seq         = SEQ_START;
        expected_size_next  = in_entry.announced_size;
        window_base_next    = '0;
        slot_bitmap_next    = '0;
        bytes_buffered_next = '0;
        total_written_next  = '0;
      end
      KIND_END: begin
        res.accepted = 1'b1;
        res.send_ack = 1'b1;
        res.ack_seq  = SEQ_END;
        if (slot_bitmap != '0) begin
          res.flush          = 1'b1;
          res.flush_bytes    = bytes_buffered;
          total_written_next = total_written + 32'(bytes_buffered);
        end
        slot_bitmap_next = '0;
        window_base_next = SEQ_END;
      end
      KIND_CSUM: begin
        res.accepted         = 1'b1;
        res.checksum_request = 1'b1;
        res.send_ack         = 1'b1;
        res.ack_seq          = SEQ_CSUM;
        window_base_next     = SEQ_CSUM;
        first_packet_next    = 1'b0;
      end
      KIND_DATA: begin
        res.accepted = 1'b1;
        if (beyond && !window_full) begin
          res.protocol_error = 1'b1;
        end else begin
          if (beyond) begin
            // window advance
            res.flush           = 1'b1;
            res.flush_bytes     = bytes_buffered;
            total_written_next  = total_written + WIN_BYTES;
            bytes_buffered_next = '0;
            slot_bitmap_next    = '0;
            window_full_next    = 1'b0;
            base_sum            = {1'b0, window_base} + 9'(WINDOW);
            window_base_next    = base_sum[7:0];
            if (window_base_next >= BASE_WRAP) begin
              window_base_next = window_base_next - BASE_WRAP;
            end
          end
          if ((slot_bitmap_next & slot_bit) == '0) begin
            slot_bitmap_next = slot_bitmap_next | slot_bit;
            res.store_chunk  = 1'b1;
            res.store_slot   = slot_ext[2:0];
            buf_sum          = {1'b0, bytes_buffered_next} + 15'(in_entry.payload_len);
            bytes_buffered_next = buf_sum[14] ? BUF_MAX : buf_sum[13:0];
          end
          slot_span = (32'(slot) + 32'd1) * 32'(CHUNK_BYTES);
          reach     = {1'b0, total_written_next} + {1'b0, slot_span};
          if (slot_bitmap_next == FULL_MASK) begin
            window_full_next = 1'b1;
            res.send_ack     = 1'b1;
          end else if (slot == SLOT_W'(WINDOW - 1) && !first_packet) begin
            res.send_ack = 1'b1;
          end else if (reach >= {1'b0, expected_size}) begin
            res.send_ack = 1'b1;
          end
          if (res.send_ack) begin
            bm_ext       = {8'd0, slot_bitmap_next};
            res.ack_seq  = window_base_next;
            res.ack_bits = bm_ext[7:0];
          end
          first_packet_next = 1'b0;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base    <= BASE_RESET;
      slot_bitmap    <= '0;
      window_full    <= 1'b0;
      bytes_buffered <= '0;
      total_written  <= '0;
      expected_size  <= '0;
      first_packet   <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (take) begin
        window_base    <= window_base_next;
        slot_bitmap    <= slot_bitmap_next;
        window_full    <= window_full_next;
        bytes_buffered <= bytes_buffered_next;
        total_written  <= total_written_next;
        expected_size  <= expected_size_next;
        first_packet   <= first_packet_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= res;
    end
  end

endmodule

FILE: rtl/core/selective_ack_window_receiver_top.sv
// ----------------------------------------------------------------------------
// selective_ack_window_receiver_top
// selective repeat receiver window and acknowledgement control
// ----------------------------------------------------------------------------
// One frame header or receive timeout is taken per cycle while the queue is
// not full, and each gives exactly one result; the header is written into the
// queue and then taken by the back stage into the output register, from which
// the result is valid on the master side. While the output is not stalled, the
// sustained rate of one per cycle is set by the window state update in the back
// stage; a four-entry queue after the header classifier lets input and output
// stall independently. The station address is written through the cfg channel,
// which is always ready. No clearing pass is needed after reset.
module selective_ack_window_receiver_top #(
  parameter int WINDOW      = 8,
  parameter int CHUNK_BYTES = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [47:0]                       cfg_data,   // own_mac
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // dest_mac, ether_type, seq, payload_len, announced_size, zero pad
  input  logic [sawr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,    // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // accepted, send_ack, ack_seq, ack_bits, store_chunk, store_slot, flush,
  // flush_bytes, checksum_request, protocol_error, zero pad
  output logic [sawr_pkg::OUT_DATA_W-1:0]   m_tdata
);
  import sawr_pkg::*;

  entry_t  front_entry;
  entry_t  head_entry;
  logic    fifo_full;
  logic    head_valid;
  logic    back_ready;
  result_t result;

  assign cfg_ready = 1'b1;
  assign s_tready  = !fifo_full;

  sawr_front #(
    .WINDOW (WINDOW)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .func           (s_tuser),
    .dest_mac       (s_tdata[47:0]),
    .ether_type     (s_tdata[63:48]),
    .seq            (s_tdata[71:64]),
    .payload_len    (s_tdata[82:72]),
    .announced_size (s_tdata[114:83]),
    .entry          (front_entry)
  );

  sawr_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (s_tvalid),
    .push_data  (front_entry),
    .full       (fifo_full),
    .pop        (back_ready),
    .head_valid (head_valid),
    .head_data  (head_entry)
  );

  sawr_back #(
    .WINDOW      (WINDOW),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (head_valid),
    .in_entry   (head_entry),
    .in_ready   (back_ready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result)
  );

  assign m_tdata = {1'b0, result.protocol_error, result.checksum_request,
                    result.flush_bytes, result.flush, result.store_slot,
                    result.store_chunk, result.ack_bits, result.ack_seq,
                    result.send_ack, result.accepted};

endmodule

FILE: rtl/core/sawr_checker.sv
// ----------------------------------------------------------------------------
// sawr_checker
// port-level checks on the selective ack window receiver
// ----------------------------------------------------------------------------
`include "selective_ack_window_receiver_top_assert.svh"

module sawr_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sawr_pkg::OUT_DATA_W-1:0] m_tdata
);

  // stalled result holds
  `SAWR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // output register empty right after reset
  `SAWR_ASSERT_NOW(a_reset_empty, $past(rst), !m_tvalid)

  // a dropped chunk is accepted and does nothing else
  `SAWR_ASSERT_NOW(a_error_alone, m_tvalid && m_tdata[38],
    m_tdata[0] && !m_tdata[1] && !m_tdata[18] && !m_tdata[22] && !m_tdata[37])

  // ignored frames and timeouts never store, flush or request a checksum
  `SAWR_ASSERT_NOW(a_not_accepted, m_tvalid && !m_tdata[0],
    !m_tdata[18] && !m_tdata[22] && !m_tdata[37] && !m_tdata[38])

  // byte count only with a flush
  `SAWR_ASSERT_NOW(a_flush_bytes, m_tvalid && !m_tdata[22], m_tdata[36:23] == 14'd0)

endmodule

bind selective_ack_window_receiver_top sawr_checker u_sawr_checker (.*);
